### rtl/core/adaptive_batch_tuner_macros.svh
// ----------------------------------------------------------------------------
// Adaptive batch tuner assertion macros
// Shared assertion shorthands for the tuner RTL.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_BATCH_TUNER_MACROS_SVH
`define ADAPTIVE_BATCH_TUNER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ABT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ABT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/abt_pkg.sv
// ----------------------------------------------------------------------------
// Adaptive batch tuner package
// Widths, register indexes, reset values and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package abt_pkg;

  localparam int unsigned VAL_W   = 24;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned PROD_W  = 2 * VAL_W;
  localparam int unsigned REM_W   = PROD_W + 1;
  localparam int unsigned DEN_W   = VAL_W + 1;
  localparam int unsigned BIT_W   = 5;

  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Register indexes
  localparam logic [IDX_W-1:0] REG_LAT_TARGET  = 3'd0;
  localparam logic [IDX_W-1:0] REG_THR_TARGET  = 3'd1;
  localparam logic [IDX_W-1:0] REG_STABLE_NEED = 3'd2;
  localparam logic [IDX_W-1:0] REG_WAIT_FLOOR  = 3'd3;
  localparam logic [IDX_W-1:0] REG_WAIT_CAP    = 3'd4;
  localparam logic [IDX_W-1:0] REG_SIZE_FLOOR  = 3'd5;
  localparam logic [IDX_W-1:0] REG_SIZE_CAP    = 3'd6;

  // Register reset values
  localparam logic [VAL_W-1:0] RST_LAT_TARGET  = 24'd1500;
  localparam logic [VAL_W-1:0] RST_THR_TARGET  = 24'd100000;
  localparam logic [CNT_W-1:0] RST_STABLE_NEED = 8'd20;
  localparam logic [VAL_W-1:0] RST_WAIT_FLOOR  = 24'd100;
  localparam logic [VAL_W-1:0] RST_WAIT_CAP    = 24'd10000;
  localparam logic [VAL_W-1:0] RST_SIZE_FLOOR  = 24'd8;
  localparam logic [VAL_W-1:0] RST_SIZE_CAP    = 24'd2048;

  // Tuning state reset values
  localparam logic [VAL_W-1:0] RST_WAIT = 24'd1000;
  localparam logic [VAL_W-1:0] RST_SIZE = 24'd64;

  // Additive increase steps
  localparam logic [VAL_W-1:0] WAIT_STEP = 24'd25;
  localparam logic [VAL_W-1:0] SIZE_STEP = 24'd4;

  localparam logic MODE_LATENCY    = 1'b0;
  localparam logic MODE_THROUGHPUT = 1'b1;

  localparam logic [BIT_W-1:0] DIV_LAST_BIT = 5'd23;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_CHK  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_FLR  = 6'b010000,
    ST_FIN  = 6'b100000
  } seq_state_t;

endpackage

`default_nettype wire

### rtl/core/adaptive_batch_tuner.sv
// ----------------------------------------------------------------------------
// Adaptive batch tuner
// AIMD controller for group-commit wait time and batch size, built around
// one shared multiplier and a bit-serial restoring divider.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  in_     | sink      | in_valid/in_stall | p99 latency, rate, rate ready
//  out_    | source    | out_valid/out_stall | mode, wait, size, skipped, changed
//  cfg_    | sink      | cfg_we            | cfg_index, cfg_data
//
//  Latency-mode events run, per value, a multiply, a range check, 24 divide
//  steps and a floor step, twice on the shared unit; a zero divisor or an
//  oversized quotient skips the divide steps.
//  Skipped and throughput-mode events go straight to the final write.
//  Reset is synchronous; it restores registers and tuning state at once.
//  in_stall is high while an event is in work; a held result beat blocks only the final write.
// ----------------------------------------------------------------------------
`default_nettype none

`include "adaptive_batch_tuner_macros.svh"

module adaptive_batch_tuner
  import abt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,

  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [VAL_W-1:0] in_p99_latency_us,
  input  wire logic [VAL_W-1:0] in_throughput_rate,
  input  wire logic             in_rate_ready,

  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_mode,
  output logic [VAL_W-1:0]      out_wait_us,
  output logic [VAL_W-1:0]      out_batch_size,
  output logic                  out_skipped,
  output logic                  out_changed,

  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [VAL_W-1:0] cfg_data
);

  // Configuration registers
  logic [VAL_W-1:0] lat_target_r;
  logic [VAL_W-1:0] thr_target_r;
  logic [CNT_W-1:0] stable_need_r;
  logic [VAL_W-1:0] wait_floor_r;
  logic [VAL_W-1:0] wait_cap_r;
  logic [VAL_W-1:0] size_floor_r;
  logic [VAL_W-1:0] size_cap_r;

  // Tuning state
  logic             mode_r,      mode_nxt;
  logic [CNT_W-1:0] stable_r,    stable_nxt;
  logic [VAL_W-1:0] wait_r,      wait_nxt;
  logic [VAL_W-1:0] size_r,      size_nxt;

  // Sequencer and shared unit
  seq_state_t       state_r,     state_nxt;
  logic             sel_r,       sel_nxt;
  logic [DEN_W-1:0] den_r,       den_nxt;
  logic [REM_W-1:0] rem_r,       rem_nxt;
  logic [PROD_W-1:0] dvs_r,      dvs_nxt;
  logic [VAL_W-1:0] quo_r,       quo_nxt;
  logic [BIT_W-1:0] bit_r,       bit_nxt;
  logic [VAL_W-1:0] new_wait_r,  new_wait_nxt;
  logic [VAL_W-1:0] new_size_r,  new_size_nxt;
  logic             skip_r,      skip_nxt;

  // Result register
  logic             out_valid_r, out_valid_nxt;
  logic             out_mode_r;
  logic [VAL_W-1:0] out_wait_r;
  logic [VAL_W-1:0] out_size_r;
  logic             out_skip_r;
  logic             out_chg_r;
  logic             out_load;

  logic             in_fire;
  logic             lat_miss;
  logic [CNT_W-1:0] stable_inc;
  logic             mode_new;
  logic [VAL_W-1:0] old_sel;
  logic [VAL_W-1:0] floor_sel;
  logic [PROD_W-1:0] prod;
  logic             sub_ok;
  logic [VAL_W-1:0] floored;

  function automatic logic [VAL_W-1:0] add_capped(input logic [VAL_W-1:0] old,
                                                  input logic [VAL_W-1:0] inc,
                                                  input logic [VAL_W-1:0] cap);
    logic [VAL_W:0] sum;
    sum = {1'b0, old} + {1'b0, inc};
    add_capped = (sum < {1'b0, cap}) ? sum[VAL_W-1:0] : cap;
  endfunction

  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;

  assign lat_miss   = (in_p99_latency_us > lat_target_r) && (in_p99_latency_us != '0);
  assign stable_inc = (stable_r == CNT_MAX) ? stable_r : stable_r + 1'b1;
  assign mode_new   = lat_miss ? MODE_LATENCY :
                      ((stable_inc >= stable_need_r) ? MODE_THROUGHPUT : mode_r);

  assign old_sel   = sel_r ? size_r : wait_r;
  assign floor_sel = sel_r ? size_floor_r : wait_floor_r;
  assign prod      = old_sel * lat_target_r;
  assign sub_ok    = (rem_r >= {1'b0, dvs_r});
  assign floored   = (quo_r < floor_sel) ? floor_sel : quo_r;

  assign out_load  = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_target_r  <= RST_LAT_TARGET;
      thr_target_r  <= RST_THR_TARGET;
      stable_need_r <= RST_STABLE_NEED;
      wait_floor_r  <= RST_WAIT_FLOOR;
      wait_cap_r    <= RST_WAIT_CAP;
      size_floor_r  <= RST_SIZE_FLOOR;
      size_cap_r    <= RST_SIZE_CAP;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LAT_TARGET:  lat_target_r  <= cfg_data;
        REG_THR_TARGET:  thr_target_r  <= cfg_data;
        REG_STABLE_NEED: stable_need_r <= cfg_data[CNT_W-1:0];
        REG_WAIT_FLOOR:  wait_floor_r  <= cfg_data;
        REG_WAIT_CAP:    wait_cap_r    <= cfg_data;
        REG_SIZE_FLOOR:  size_floor_r  <= cfg_data;
        REG_SIZE_CAP:    size_cap_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt    = state_r;
    sel_nxt      = sel_r;
    den_nxt      = den_r;
    rem_nxt      = rem_r;
    dvs_nxt      = dvs_r;
    quo_nxt      = quo_r;
    bit_nxt      = bit_r;
    new_wait_nxt = new_wait_r;
    new_size_nxt = new_size_r;
    skip_nxt     = skip_r;
    mode_nxt     = mode_r;
    stable_nxt   = stable_r;
    wait_nxt     = wait_r;
    size_nxt     = size_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          new_wait_nxt = wait_r;
          new_size_nxt = size_r;
          skip_nxt     = !in_rate_ready;
          state_nxt    = ST_FIN;
          if (in_rate_ready) begin
            mode_nxt   = mode_new;
            stable_nxt = lat_miss ? '0 : stable_inc;
            if (mode_new == MODE_LATENCY) begin
              den_nxt   = {1'b0, lat_target_r} + {1'b0, in_p99_latency_us};
              sel_nxt   = 1'b0;
              state_nxt = ST_MUL;
            end else if (in_throughput_rate < thr_target_r) begin
              new_wait_nxt = add_capped(wait_r, WAIT_STEP, wait_cap_r);
              new_size_nxt = add_capped(size_r, SIZE_STEP, size_cap_r);
            end
          end
        end
      end
      ST_MUL: begin
        rem_nxt   = {prod, 1'b0};
        dvs_nxt   = {den_r, {(PROD_W-DEN_W){1'b0}}};
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        // zero divisor keeps the old value; a quotient past 24 bits saturates
        if (den_r == '0) begin
          quo_nxt   = old_sel;
          state_nxt = ST_FLR;
        end else if (rem_r >= {den_r, {VAL_W{1'b0}}}) begin
          quo_nxt   = VAL_MAX;
          state_nxt = ST_FLR;
        end else begin
          quo_nxt   = '0;
          bit_nxt   = DIV_LAST_BIT;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sub_ok) begin
          rem_nxt = rem_r - {1'b0, dvs_r};
        end
        quo_nxt = {quo_r[VAL_W-2:0], sub_ok};
        dvs_nxt = dvs_r >> 1;
        if (bit_r == '0) begin
          state_nxt = ST_FLR;
        end else begin
          bit_nxt = bit_r - 1'b1;
        end
      end
      ST_FLR: begin
        if (!sel_r) begin
          new_wait_nxt = floored;
          sel_nxt      = 1'b1;
          state_nxt    = ST_MUL;
        end else begin
          new_size_nxt = floored;
          state_nxt    = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the result register is free
        if (out_load) begin
          wait_nxt  = new_wait_r;
          size_nxt  = new_size_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_LATENCY;
      stable_r    <= '0;
      wait_r      <= RST_WAIT;
      size_r      <= RST_SIZE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      stable_r    <= stable_nxt;
      wait_r      <= wait_nxt;
      size_r      <= size_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r      <= sel_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    dvs_r      <= dvs_nxt;
    quo_r      <= quo_nxt;
    bit_r      <= bit_nxt;
    new_wait_r <= new_wait_nxt;
    new_size_r <= new_size_nxt;
    skip_r     <= skip_nxt;
    if (out_load) begin
      out_mode_r <= mode_r;
      out_wait_r <= new_wait_r;
      out_size_r <= new_size_r;
      out_skip_r <= skip_r;
      out_chg_r  <= (new_wait_r != wait_r) || (new_size_r != size_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mode       = out_mode_r;
  assign out_wait_us    = out_wait_r;
  assign out_batch_size = out_size_r;
  assign out_skipped    = out_skip_r;
  assign out_changed    = out_chg_r;

  `ABT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, in_stall, "accepted beat did not stall input")
  `ABT_ASSERT_SAME(a_div_rem_bound, clk, rst_n, state_r == ST_DIV, rem_r < {dvs_r, 1'b0}, "divider remainder out of range")
  `ABT_ASSERT_NEXT(a_fin_loads_out, clk, rst_n, (state_r == ST_FIN) && !out_valid_r, out_valid_r && (state_r == ST_IDLE), "finished result not loaded")
  `ABT_ASSERT_SAME(a_skip_no_change, clk, rst_n, out_valid_r && out_skip_r, !out_chg_r, "skipped beat reports a change")

endmodule

`default_nettype wire
